@@ hw/rtl/gbts_pkg.sv @@
// Shared types, codes and defaults for the gap buffer text store.
package gbts_pkg;

    // Default text capacity in bytes
    localparam int CAPACITY_DEF = 1024;

    // Operation codes
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_MOVE    = 3'd1;
    localparam logic [2:0] OP_DEL_LFT = 3'd2;
    localparam logic [2:0] OP_DEL_RGT = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // One input item
    typedef struct packed {
        logic [2:0]         opcode;
        logic [7:0]         char_in;
        logic               string_end;
        logic signed [11:0] move_offset;
        logic [10:0]        amount;
        logic [9:0]         read_index;
    } item_t;

    // One result item
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_data;
        logic [10:0] cursor;
        logic [10:0] text_length;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic step;
        logic load_out;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_move;
        logic op_read;
        logic cnt_zero;
    } dp_stat_t;

endpackage

@@ hw/rtl/gbts_item_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface gbts_item_if;
    logic            valid;
    logic            ready;
    gbts_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbts_result_if;
    logic              valid;
    logic              ready;
    gbts_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/gbts_datapath.sv @@
// Datapath: gap pointers, text memory, move counter and result register.
module gbts_datapath #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gbts_pkg::ctl_cmd_t cmd,
    output gbts_pkg::dp_stat_t stat,
    input  gbts_pkg::item_t    item_in,
    output gbts_pkg::result_t  result
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = ((PW > 12) ? PW : 12) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [PW-1:0] ONE_P = PW'(1);

    gbts_pkg::item_t   item_reg;
    gbts_pkg::result_t result_reg;
    gbts_pkg::result_t result_next;

    logic [PW-1:0] gs_reg, gs_next;
    logic [PW-1:0] ge_reg, ge_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          left_reg;
    logic [1:0]    st_reg;
    logic          rd_ok_reg;
    logic          wr_pend_reg;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;

    logic [7:0]    mem [CAPACITY];
    logic [7:0]    mem_q;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic [CW-1:0] gs_c, ge_c, gap_c, len_c, room_c;
    logic [CW-1:0] amt_c, idx_c, mag_c, avail_c, dist_c, phys_c;
    logic [CW-1:0] dl_n, dr_n, gs_dl, ge_dr;
    logic [11:0]   mag12;
    logic          neg, mv_clamp, dl_clamp, dr_clamp, rd_range, full;
    logic          do_insert;
    logic [1:0]    exec_status;
    logic [PW-1:0] gs_dec, ge_dec, gs_inc, ge_inc, len_next;
    logic [PW+10:0] cur_ext, len_ext;

    // Widen pointers and fields to one compare width
    always_comb
    begin
        gs_c   = {{(CW-PW){1'b0}}, gs_reg};
        ge_c   = {{(CW-PW){1'b0}}, ge_reg};
        gap_c  = ge_c - gs_c;
        len_c  = CAP_C - gap_c;
        room_c = CAP_C - ge_c;
        amt_c  = {{(CW-11){1'b0}}, item_reg.amount};
        idx_c  = {{(CW-10){1'b0}}, item_reg.read_index};
    end

    // Clamp the move distance to the text on the chosen side
    always_comb
    begin
        neg      = item_reg.move_offset[11];
        mag12    = neg ? (12'd0 - item_reg.move_offset) : item_reg.move_offset;
        mag_c    = {{(CW-12){1'b0}}, mag12};
        avail_c  = neg ? gs_c : room_c;
        mv_clamp = mag_c > avail_c;
        dist_c   = mv_clamp ? avail_c : mag_c;
    end

    // Clamp delete counts and locate the read byte past the gap
    always_comb
    begin
        dl_clamp = amt_c > gs_c;
        dl_n     = dl_clamp ? gs_c : amt_c;
        gs_dl    = gs_c - dl_n;
        dr_clamp = amt_c > room_c;
        dr_n     = dr_clamp ? room_c : amt_c;
        ge_dr    = ge_c + dr_n;
        phys_c   = (idx_c >= gs_c) ? (idx_c + gap_c) : idx_c;
        rd_range = (idx_c >= len_c) || (phys_c >= CAP_C);
        full     = gs_reg >= ge_reg;
    end

    // Pick the status of the current operation
    always_comb
    begin
        unique case (item_reg.opcode)
            gbts_pkg::OP_INSERT:  exec_status = full ? gbts_pkg::ST_FULL : gbts_pkg::ST_OK;
            gbts_pkg::OP_MOVE:    exec_status = mv_clamp ? gbts_pkg::ST_CLAMP : gbts_pkg::ST_OK;
            gbts_pkg::OP_DEL_LFT: exec_status = dl_clamp ? gbts_pkg::ST_CLAMP : gbts_pkg::ST_OK;
            gbts_pkg::OP_DEL_RGT: exec_status = dr_clamp ? gbts_pkg::ST_CLAMP : gbts_pkg::ST_OK;
            gbts_pkg::OP_READ:    exec_status = rd_range ? gbts_pkg::ST_RANGE : gbts_pkg::ST_OK;
            default:              exec_status = gbts_pkg::ST_OK;
        endcase
    end

    // Update the gap pointers on insert, delete and move steps
    always_comb
    begin
        gs_dec  = gs_reg - ONE_P;
        ge_dec  = ge_reg - ONE_P;
        gs_inc  = gs_reg + ONE_P;
        ge_inc  = ge_reg + ONE_P;
        do_insert = cmd.exec && (item_reg.opcode == gbts_pkg::OP_INSERT) && !full;
        gs_next = gs_reg;
        ge_next = ge_reg;
        if (cmd.exec)
        begin
            unique case (item_reg.opcode)
                gbts_pkg::OP_INSERT:  gs_next = full ? gs_reg : gs_inc;
                gbts_pkg::OP_DEL_LFT: gs_next = gs_dl[PW-1:0];
                gbts_pkg::OP_DEL_RGT: ge_next = ge_dr[PW-1:0];
                default:              gs_next = gs_reg;
            endcase
        end
        else if (cmd.step)
        begin
            gs_next = left_reg ? gs_dec : gs_inc;
            ge_next = left_reg ? ge_dec : ge_inc;
        end
    end

    // Steer the memory ports: insert or move write-back, read or move fetch
    always_comb
    begin
        mem_we       = do_insert || wr_pend_reg;
        mem_waddr    = wr_pend_reg ? wr_addr_reg : gs_reg[AW-1:0];
        mem_wdata    = wr_pend_reg ? mem_q : item_reg.char_in;
        mem_re       = cmd.step ||
                       (cmd.exec && (item_reg.opcode == gbts_pkg::OP_READ) && !rd_range);
        mem_raddr    = cmd.step ? (left_reg ? gs_dec[AW-1:0] : ge_reg[AW-1:0])
                                : phys_c[AW-1:0];
        wr_addr_next = left_reg ? ge_dec[AW-1:0] : gs_reg[AW-1:0];
        cnt_next     = cnt_reg;
        if (cmd.exec)
            cnt_next = dist_c;
        else if (cmd.step)
            cnt_next = cnt_reg - CW'(1);
    end

    // Build the result from post-operation pointers
    always_comb
    begin
        len_next    = CAP_P - (ge_next - gs_next);
        cur_ext     = {11'd0, gs_next};
        len_ext     = {11'd0, len_next};
        result_next.status      = cmd.exec ? exec_status : st_reg;
        result_next.read_data   = (!cmd.exec && rd_ok_reg) ? mem_q : 8'd0;
        result_next.cursor      = cur_ext[10:0];
        result_next.text_length = len_ext[10:0];
    end

    // Hold the text store and its registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg      <= '0;
            ge_reg      <= CAP_P;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            gs_reg      <= gs_next;
            ge_reg      <= ge_next;
            wr_pend_reg <= cmd.step;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= item_in;
        if (cmd.exec)
        begin
            left_reg  <= neg;
            st_reg    <= exec_status;
            rd_ok_reg <= (item_reg.opcode == gbts_pkg::OP_READ) && !rd_range;
        end
        cnt_reg     <= cnt_next;
        wr_addr_reg <= wr_addr_next;
        if (cmd.load_out)
            result_reg <= result_next;
    end

    assign stat.op_move  = item_reg.opcode == gbts_pkg::OP_MOVE;
    assign stat.op_read  = item_reg.opcode == gbts_pkg::OP_READ;
    assign stat.cnt_zero = cnt_reg == '0;
    assign result        = result_reg;

endmodule

@@ hw/rtl/gbts_ctrl.sv @@
// Controller: sequences accept, execute, gap move steps and result transfer.
module gbts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  gbts_pkg::dp_stat_t stat,
    output gbts_pkg::ctl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready = state_reg == S_IDLE;
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.exec     = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.op_move)
                    state_next = S_MOVE;
                else if (stat.op_read)
                    state_next = S_FIN;
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                    state_next = S_FIN;
            end
            S_MOVE:
            begin
                if (stat.cnt_zero)
                    state_next = S_FIN;
                else
                    cmd.step = 1'b1;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // Hold the result until its transfer
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/gap_buffer_text_store_top.sv @@
// Gap buffer text store: items channel in, results channel out.
//
// Each item on the items channel carries one edit operation (insert, move
// gap, delete left, delete right, read); each yields exactly one result
// with status, read data, cursor and text length on the results channel.
// Items are worked one at a time; items.ready is high only while idle.
// Steps per item, from its acceptance to the next acceptance:
//   insert, delete, unknown opcode: accept, then execute and load the result
//   read: accept, execute with one registered access of the text memory, load
//   move: accept, execute, step the gap over the clamped distance, load;
//         the gap crosses one byte a cycle through the memory read and write ports.
// Reset empties the text: cursor 0, gap spanning the whole capacity. The
// text memory itself is not cleared and needs no clearing pass.
// The result sits in an output register, so the next item is taken while a
// result waits; if the receiver stalls, the block finishes that item and
// then holds it until results.ready frees the register.
module gap_buffer_text_store_top #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    gbts_item_if.sink     items,
    gbts_result_if.source results
);

    gbts_pkg::ctl_cmd_t cmd;
    gbts_pkg::dp_stat_t stat;

    gbts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gbts_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .item_in (items.data),
        .result  (results.data)
    );

endmodule

@@ hw/rtl/gbts_checker.sv @@
// Port-level checker for the gap buffer text store, bound to the top level.
module gbts_checker #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input gbts_pkg::result_t out_data
);

    localparam logic [10:0] CAP11 = 11'(CAPACITY);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    // A full buffer reports the whole capacity as text
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == gbts_pkg::ST_FULL) |->
        out_data.text_length == CAP11)
        else $error("full status with spare room");

    // Read data only comes with an ok status
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.read_data != 8'd0) |->
        out_data.status == gbts_pkg::ST_OK)
        else $error("read data with error status");

endmodule

bind gap_buffer_text_store_top gbts_checker #(
    .CAPACITY (CAPACITY)
) u_gbts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);

@@ tb/gap_buffer_text_store_check.sv @@
`timescale 1ns / 1ps
// Watches both channels, predicts each edit result and compares it field by field.
module gap_buffer_text_store_check
    import gbts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    gbts_item_if   items,
    gbts_result_if results,
    output int     fail_count,
    output int     pending
);

    // Local copy of the text store and its gap
    logic [7:0] text_mem [CAPACITY];
    int         gap_lo;
    int         gap_hi;
    result_t    expected_q [$];

    // Apply one edit to the local store and return the result it should give
    function automatic result_t apply_edit(item_t e);
        result_t r;
        int      span;
        int      idx;
        r = '0;
        r.status = ST_OK;
        case (e.opcode)
            OP_INSERT:
            begin
                if (gap_lo >= gap_hi)
                    r.status = ST_FULL;
                else
                begin
                    text_mem[gap_lo] = e.char_in;
                    gap_lo++;
                end
            end
            OP_MOVE:
            begin
                span = $signed(e.move_offset);
                if (span < 0)
                begin
                    span = -span;
                    if (span > gap_lo)
                    begin
                        span = gap_lo;
                        r.status = ST_CLAMP;
                    end
                    // carry bytes from the left of the gap across to its right end
                    for (int k = 0; k < span; k++)
                    begin
                        gap_lo--;
                        gap_hi--;
                        text_mem[gap_hi] = text_mem[gap_lo];
                    end
                end
                else if (span > 0)
                begin
                    if (span > CAPACITY - gap_hi)
                    begin
                        span = CAPACITY - gap_hi;
                        r.status = ST_CLAMP;
                    end
                    for (int k = 0; k < span; k++)
                    begin
                        text_mem[gap_lo] = text_mem[gap_hi];
                        gap_lo++;
                        gap_hi++;
                    end
                end
            end
            OP_DEL_LFT:
            begin
                span = e.amount;
                if (span > gap_lo)
                begin
                    span = gap_lo;
                    r.status = ST_CLAMP;
                end
                gap_lo -= span;
            end
            OP_DEL_RGT:
            begin
                span = e.amount;
                if (span > CAPACITY - gap_hi)
                begin
                    span = CAPACITY - gap_hi;
                    r.status = ST_CLAMP;
                end
                gap_hi += span;
            end
            OP_READ:
            begin
                idx = e.read_index;
                if (idx >= CAPACITY - (gap_hi - gap_lo))
                    r.status = ST_RANGE;
                else
                begin
                    // skip over the gap for positions at or past the cursor
                    if (idx >= gap_lo)
                        idx += gap_hi - gap_lo;
                    r.read_data = text_mem[idx];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor      = 11'(gap_lo);
        r.text_length = 11'(CAPACITY - (gap_hi - gap_lo));
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Retire results against the oldest prediction, then queue new predictions
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            gap_lo = 0;
            gap_hi = CAPACITY;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got = results.data;
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with nothing pending: status %0d cursor %0d",
                           got.status, got.cursor);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("cursor", want.cursor, got.cursor);
                    check_field("text_length", want.text_length, got.text_length);
                end
            end
            if (items.valid && items.ready)
                expected_q.push_back(apply_edit(items.data));
        end
        pending = expected_q.size();
    end

endmodule

@@ tb/gap_buffer_text_store_top_test.sv @@
`timescale 1ns / 1ps
// Top-level testbench: edit stimulus, result back-pressure, watchdog and verdict.
module gap_buffer_text_store_top_test;
    import gbts_pkg::*;

    localparam int         RANDOM_EDITS    = 1800;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         WATCHDOG_LIMIT  = 8000;
    localparam int         EDIT_BITS       = $bits(item_t);
    localparam logic [2:0] OP_LAST         = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    gbts_item_if   items ();
    gbts_result_if results ();

    int fail_count;
    int pending;
    int edits_sent  = 0;
    int idle_cycles = 0;
    bit quiet_run    = 1'b0;
    bit hold_off_req = 1'b0;

    gap_buffer_text_store_top #(
        .CAPACITY (CAPACITY_DEF)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    gap_buffer_text_store_check #(
        .CAPACITY (CAPACITY_DEF)
    ) edit_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .results    (results),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Edit with random junk in the fields the operation ignores
    function automatic item_t raw_edit(logic [2:0] op);
        item_t e;
        e = EDIT_BITS'({$urandom(), $urandom()});
        e.opcode = op;
        return e;
    endfunction

    function automatic item_t insert_edit(logic [7:0] ch, logic last);
        item_t e;
        e = raw_edit(OP_INSERT);
        e.char_in    = ch;
        e.string_end = last;
        return e;
    endfunction

    function automatic item_t move_edit(int off);
        item_t e;
        e = raw_edit(OP_MOVE);
        e.move_offset = 12'(off);
        return e;
    endfunction

    function automatic item_t delete_edit(logic [2:0] op, int unsigned amt);
        item_t e;
        e = raw_edit(op);
        e.amount = 11'(amt);
        return e;
    endfunction

    function automatic item_t read_edit(int unsigned idx);
        item_t e;
        e = raw_edit(OP_READ);
        e.read_index = 10'(idx);
        return e;
    endfunction

    // Offer one edit, with an optional idle gap first, and hold it until transfer
    task automatic send_edit(input item_t e);
        int gap;
        gap = quiet_run ? 0 : pick_gap();
        if (gap > 0)
        begin
            items.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.data  <= e;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        if (e.opcode <= OP_READ)
            edits_sent++;
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic drain();
        items.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        results.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            else
                stall = pick_gap();
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results.ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Abort when no transfer happens on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (items.valid && items.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("gap_buffer_text_store_top regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int k;
        int n;
        int r;
        int kind;
        int off;
        int unsigned amt;
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n = 1'b0;
        items.valid <= 1'b0;
        items.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty buffer: out-of-range read, zero and clamped deletes and moves
        send_edit(read_edit(0));
        send_edit(delete_edit(OP_DEL_LFT, 0));
        send_edit(delete_edit(OP_DEL_RGT, 2047));
        send_edit(move_edit(-1024));
        send_edit(move_edit(2047));
        // Short string with extreme characters, then reads across the gap
        send_edit(insert_edit(8'h00, 1'b0));
        send_edit(insert_edit(8'hFF, 1'b0));
        send_edit(insert_edit(8'hA5, 1'b1));
        send_edit(move_edit(0));
        send_edit(read_edit(0));
        send_edit(read_edit(2));
        send_edit(read_edit(1023));
        send_edit(move_edit(-2));
        send_edit(insert_edit(8'h5A, 1'b1));
        send_edit(read_edit(1));
        send_edit(read_edit(2));
        send_edit(move_edit(-2048));
        send_edit(read_edit(3));
        send_edit(delete_edit(OP_DEL_RGT, 1));
        send_edit(move_edit(1024));
        send_edit(delete_edit(OP_DEL_LFT, 1024));
        send_edit(delete_edit(OP_DEL_RGT, 0));
        // Undefined opcodes must act as no-ops
        for (k = int'(OP_READ) + 1; k <= int'(OP_LAST); k++)
            send_edit(raw_edit(3'(k)));
        drain();

        // Random bursts: strings, moves, deletes, reads and raw noise
        edits_sent = 0;
        while (edits_sent < RANDOM_EDITS)
        begin
            if (!hold_done && edits_sent >= RANDOM_EDITS / 3)
            begin
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
            end
            if (!drain_done && edits_sent >= 2 * RANDOM_EDITS / 3)
            begin
                drain_done = 1'b1;
                drain();
            end
            quiet_run = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                // one string; long ones push the buffer to full
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
                for (k = 0; k < n; k++)
                    send_edit(insert_edit(8'($urandom_range(0, 255)),
                                          (k == n - 1) && ($urandom_range(0, 9) != 0)));
            end
            else if (kind < 65)
            begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        off = int'($urandom_range(0, 64)) - 32;
                    else if (r < 85)
                        off = int'($urandom_range(0, 600)) - 300;
                    else if (r < 98)
                        off = int'($urandom_range(0, 2048)) - 1024;
                    else
                        off = int'($urandom_range(0, 4095)) - 2048;
                    send_edit(move_edit(off));
                end
            end
            else if (kind < 80)
            begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        amt = $urandom_range(0, 4);
                    else if (r < 97)
                        amt = $urandom_range(0, 40);
                    else if (r < 99)
                        amt = $urandom_range(0, 1024);
                    else
                        amt = $urandom_range(0, 2047);
                    send_edit(delete_edit((kind < 72) ? OP_DEL_LFT : OP_DEL_RGT, amt));
                end
            end
            else if (kind < 95)
            begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    send_edit(read_edit(($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                                    : $urandom_range(0, 1023)));
            end
            else
                send_edit(EDIT_BITS'({$urandom(), $urandom()}));
        end
        quiet_run = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("gap_buffer_text_store_top regression: pass");
        else
            $display("gap_buffer_text_store_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/gbts_pkg.sv
hw/rtl/gbts_item_if.sv
hw/rtl/gbts_datapath.sv
hw/rtl/gbts_ctrl.sv
hw/rtl/gap_buffer_text_store_top.sv
hw/rtl/gbts_checker.sv
tb/gap_buffer_text_store_check.sv
tb/gap_buffer_text_store_top_test.sv
